[sv/gat_pkg.sv]
// gat_pkg: sizes, operation and status codes, and the command/status structs
// shared by the graph adjacency table controller and datapath
// no dependencies
`timescale 1ns / 1ps

package gat_pkg;

	// table dimensions
	localparam int MAX_VERTICES         = 16;
	localparam int MAX_EDGES_PER_VERTEX = 16;

	// field widths
	localparam int OP_W = 2;
	localparam int ID_W = 16;
	localparam int WT_W = 16;
	localparam int ST_W = 3;

	// derived widths
	localparam int SLOT_W     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int EIDX_W     = (MAX_EDGES_PER_VERTEX > 1) ? $clog2(MAX_EDGES_PER_VERTEX) : 1;
	localparam int CNT_W      = $clog2(MAX_EDGES_PER_VERTEX + 1);
	localparam int EDGE_DEPTH = MAX_VERTICES * MAX_EDGES_PER_VERTEX;
	localparam int EDGE_AW    = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_ADD_VERTEX = 2'd0,
		OP_DEL_VERTEX = 2'd1,
		OP_ADD_EDGE   = 2'd2
	} op_t;

	// result status codes
	typedef enum logic [ST_W-1:0] {
		ST_ADDED       = 3'd0,
		ST_EXISTS      = 3'd1,
		ST_DELETED     = 3'd2,
		ST_NOT_FOUND   = 3'd3,
		ST_EDGE_ADDED  = 3'd4,
		ST_EDGE_EXISTS = 3'd5,
		ST_INVALID     = 3'd6,
		ST_FULL        = 3'd7
	} status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // capture the incoming word, clear search state
		logic slot_rd;   // issue a slot id read and step the slot index
		logic list_rd;   // issue an edge list read and step the list index
		logic slot_add;  // claim the first free slot for the new id
		logic slot_del;  // free the matched slot and its list
		logic edge_wr1;  // append to the origin list
		logic edge_wr2;  // append to the destination list
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            found_a;
		logic            found_b;
		logic            free_found;
		logic            slot_last;
		logic            list_empty;
		logic            list_last;
		logic            list_hit;
		logic            room_ok;
	} dp_stat_t;

endpackage

[sv/graph_adjacency_table_unit.sv]
// graph_adjacency_table_unit: top level of the graph adjacency table
// depends on gat_pkg, gat_ctrl, gat_datapath (and gat_ram through the datapath)
`timescale 1ns / 1ps

// Keeps up to MAX_VERTICES vertex ids, each with a list of up to
// MAX_EDGES_PER_VERTEX (neighbour, weight) entries, and answers every request
// word (add vertex, delete vertex, add undirected edge) with one status word.
// Requests are handled one at a time: every request first reads the slot id
// memory one entry a cycle, and add edge then reads the origin's edge list,
// when it is not empty, one entry a cycle. The next request is taken once the
// controller has returned to idle, which it does as the status word is
// offered. The search time is set by the single read port of each memory.
// The status word sits in an output register, so a new request can be taken
// while the previous status still waits to be collected. No clearing pass is
// needed after reset.

module graph_adjacency_table_unit
	import gat_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  logic [OP_W-1:0]        operation,
	input  logic [ID_W-1:0]        vertex_id,
	input  logic [ID_W-1:0]        other_id,
	input  logic signed [WT_W-1:0] edge_weight,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output logic [ST_W-1:0]        status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	gat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.stat      (stat),
		.cmd       (cmd)
	);

	gat_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.operation   (operation),
		.vertex_id   (vertex_id),
		.other_id    (other_id),
		.edge_weight (edge_weight),
		.stat        (stat)
	);

endmodule

[sv/gat_ram.sv]
// gat_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module gat_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/gat_datapath.sv]
// gat_datapath: slot and edge memories, slot flags and edge counts, search logic
// depends on gat_pkg and gat_ram
`timescale 1ns / 1ps

module gat_datapath
	import gat_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	input  logic [OP_W-1:0]        operation,
	input  logic [ID_W-1:0]        vertex_id,
	input  logic [ID_W-1:0]        other_id,
	input  logic signed [WT_W-1:0] edge_weight,
	output dp_stat_t               stat
);

	// captured word
	logic [OP_W-1:0] op_q;
	logic [ID_W-1:0] vid_q;
	logic [ID_W-1:0] oid_q;
	logic [WT_W-1:0] wt_q;

	// slot search state
	logic [SLOT_W-1:0] slot_idx_q;
	logic [SLOT_W-1:0] cmp_idx_s1;
	logic              slot_cmp_s1;
	logic              found_a_q;
	logic              found_b_q;
	logic              free_found_q;
	logic [SLOT_W-1:0] sa_q;
	logic [SLOT_W-1:0] sb_q;
	logic [SLOT_W-1:0] free_q;
	logic [CNT_W-1:0]  cnt_a_q;
	logic [CNT_W-1:0]  cnt_b_q;

	// list search state
	logic [EIDX_W-1:0] list_idx_q;
	logic              list_cmp_s1;
	logic              hit_q;

	// per-slot flags and counts
	logic [MAX_VERTICES-1:0] slot_valid_q;
	logic [CNT_W-1:0]        edge_count_q [MAX_VERTICES];

	// memory ports
	logic [ID_W-1:0]        slot_rdata;
	logic                   edge_we;
	logic [EDGE_AW-1:0]     edge_waddr;
	logic [EDGE_AW-1:0]     edge_raddr;
	logic [WT_W+ID_W-1:0]   edge_wdata;
	logic [WT_W+ID_W-1:0]   edge_rdata;

	// derived values
	logic              slot_match_a;
	logic              slot_match_b;
	logic              slot_free;
	logic              list_match;
	logic              self_loop;
	logic              slot_last;
	logic [CNT_W-1:0]  cnt_a_inc;
	logic [CNT_W-1:0]  cnt_b_inc;
	logic [CNT_W:0]    cnt_a_inc2;
	logic [CNT_W-1:0]  wr2_idx;
	logic [CNT_W-1:0]  wr2_cnt;
	logic              room_ok;

	function automatic logic [EDGE_AW-1:0] edge_addr(
		input logic [SLOT_W-1:0] s,
		input logic [EIDX_W-1:0] k
	);
		return EDGE_AW'(s) * EDGE_AW'(MAX_EDGES_PER_VERTEX) + EDGE_AW'(k);
	endfunction

	gat_ram #(
		.WIDTH (ID_W),
		.DEPTH (MAX_VERTICES)
	) u_slot_ram (
		.clk   (clk),
		.we    (cmd.slot_add),
		.waddr (free_q),
		.wdata (vid_q),
		.raddr (slot_idx_q),
		.rdata (slot_rdata)
	);

	gat_ram #(
		.WIDTH (WT_W + ID_W),
		.DEPTH (EDGE_DEPTH)
	) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata (edge_wdata),
		.raddr (edge_raddr),
		.rdata (edge_rdata)
	);

	// compares on the word read back last cycle
	assign slot_match_a = slot_cmp_s1 && slot_valid_q[cmp_idx_s1] && (slot_rdata == vid_q);
	assign slot_match_b = slot_cmp_s1 && slot_valid_q[cmp_idx_s1] && (slot_rdata == oid_q);
	assign slot_free    = slot_cmp_s1 && !slot_valid_q[cmp_idx_s1];
	assign list_match   = list_cmp_s1 && (edge_rdata[ID_W-1:0] == oid_q);
	assign slot_last    = (slot_idx_q == SLOT_W'(MAX_VERTICES - 1));

	// room check and append positions
	assign self_loop  = (sa_q == sb_q);
	assign cnt_a_inc  = cnt_a_q + CNT_W'(1);
	assign cnt_b_inc  = cnt_b_q + CNT_W'(1);
	assign cnt_a_inc2 = {1'b0, cnt_a_q} + (CNT_W+1)'(2);
	assign wr2_idx    = self_loop ? cnt_a_inc : cnt_b_q;
	assign wr2_cnt    = self_loop ? cnt_a_inc2[CNT_W-1:0] : cnt_b_inc;
	assign room_ok    = self_loop
		? (cnt_a_inc2 <= (CNT_W+1)'(MAX_EDGES_PER_VERTEX))
		: ((cnt_a_q < CNT_W'(MAX_EDGES_PER_VERTEX)) && (cnt_b_q < CNT_W'(MAX_EDGES_PER_VERTEX)));

	// edge memory addressing
	assign edge_we    = cmd.edge_wr1 || cmd.edge_wr2;
	assign edge_waddr = cmd.edge_wr1 ? edge_addr(sa_q, cnt_a_q[EIDX_W-1:0])
	                                 : edge_addr(sb_q, wr2_idx[EIDX_W-1:0]);
	assign edge_wdata = {wt_q, (cmd.edge_wr1 ? oid_q : vid_q)};
	assign edge_raddr = edge_addr(sa_q, list_idx_q);

	// status to the controller
	always_comb begin
		stat            = '0;
		stat.op         = op_q;
		stat.found_a    = found_a_q;
		stat.found_b    = found_b_q;
		stat.free_found = free_found_q;
		stat.slot_last  = slot_last;
		stat.list_empty = (cnt_a_q == '0);
		stat.list_last  = ((CNT_W'(list_idx_q) + CNT_W'(1)) == cnt_a_q);
		stat.list_hit   = hit_q;
		stat.room_ok    = room_ok;
	end

	// captured word and compare pipeline payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			vid_q <= vertex_id;
			oid_q <= other_id;
			wt_q  <= edge_weight;
		end
		cmp_idx_s1 <= slot_idx_q;
		if (slot_match_a && !found_a_q) begin
			sa_q    <= cmp_idx_s1;
			cnt_a_q <= edge_count_q[cmp_idx_s1];
		end
		if (slot_match_b && !found_b_q) begin
			sb_q    <= cmp_idx_s1;
			cnt_b_q <= edge_count_q[cmp_idx_s1];
		end
		if (slot_free && !free_found_q) begin
			free_q <= cmp_idx_s1;
		end
	end

	// search control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_idx_q   <= '0;
			slot_cmp_s1  <= 1'b0;
			found_a_q    <= 1'b0;
			found_b_q    <= 1'b0;
			free_found_q <= 1'b0;
			list_idx_q   <= '0;
			list_cmp_s1  <= 1'b0;
			hit_q        <= 1'b0;
		end else begin
			slot_cmp_s1 <= cmd.slot_rd;
			list_cmp_s1 <= cmd.list_rd;
			if (cmd.load) begin
				slot_idx_q   <= '0;
				list_idx_q   <= '0;
				found_a_q    <= 1'b0;
				found_b_q    <= 1'b0;
				free_found_q <= 1'b0;
				hit_q        <= 1'b0;
			end else begin
				if (cmd.slot_rd) begin
					slot_idx_q <= slot_last ? '0 : slot_idx_q + SLOT_W'(1);
				end
				if (cmd.list_rd) begin
					list_idx_q <= list_idx_q + EIDX_W'(1);
				end
				if (slot_match_a) begin
					found_a_q <= 1'b1;
				end
				if (slot_match_b) begin
					found_b_q <= 1'b1;
				end
				if (slot_free) begin
					free_found_q <= 1'b1;
				end
				if (list_match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// slot flags and edge counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			for (int i = 0; i < MAX_VERTICES; i++) begin
				edge_count_q[i] <= '0;
			end
		end else begin
			if (cmd.slot_add) begin
				slot_valid_q[free_q] <= 1'b1;
				edge_count_q[free_q] <= '0;
			end
			if (cmd.slot_del) begin
				slot_valid_q[sa_q] <= 1'b0;
				edge_count_q[sa_q] <= '0;
			end
			if (cmd.edge_wr1) begin
				edge_count_q[sa_q] <= cnt_a_inc;
			end
			if (cmd.edge_wr2) begin
				edge_count_q[sb_q] <= wr2_cnt;
			end
		end
	end

endmodule

[sv/gat_ctrl.sv]
// gat_ctrl: operation sequencer, issues datapath commands and holds the result word
// depends on gat_pkg
`timescale 1ns / 1ps

module gat_ctrl
	import gat_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output logic [ST_W-1:0] status,
	input  dp_stat_t        stat,
	output dp_cmd_t         cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SLOT_SCAN,
		S_SLOT_DRAIN,
		S_DECIDE,
		S_LIST_SCAN,
		S_LIST_DRAIN,
		S_EDGE_CHECK,
		S_EDGE_WR2,
		S_RESULT
	} state_t;

	state_t          state_q;
	state_t          state_d;
	status_t         st_q;
	status_t         st_d;
	logic            rsp_valid_q;
	logic [ST_W-1:0] status_q;
	logic            out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SLOT_SCAN;
				end
			end
			S_SLOT_SCAN: begin
				cmd.slot_rd = 1'b1;
				if (stat.slot_last) begin
					state_d = S_SLOT_DRAIN;
				end
			end
			S_SLOT_DRAIN: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_RESULT;
				case (stat.op)
					OP_ADD_VERTEX: begin
						if (stat.found_a) begin
							st_d = ST_EXISTS;
						end else if (stat.free_found) begin
							cmd.slot_add = 1'b1;
							st_d         = ST_ADDED;
						end else begin
							st_d = ST_FULL;
						end
					end
					OP_DEL_VERTEX: begin
						if (stat.found_a) begin
							cmd.slot_del = 1'b1;
							st_d         = ST_DELETED;
						end else begin
							st_d = ST_NOT_FOUND;
						end
					end
					OP_ADD_EDGE: begin
						if (!(stat.found_a && stat.found_b)) begin
							st_d = ST_INVALID;
						end else if (stat.list_empty) begin
							state_d = S_EDGE_CHECK;
						end else begin
							state_d = S_LIST_SCAN;
						end
					end
					default: begin
						st_d = ST_INVALID;
					end
				endcase
			end
			S_LIST_SCAN: begin
				cmd.list_rd = 1'b1;
				if (stat.list_last) begin
					state_d = S_LIST_DRAIN;
				end
			end
			S_LIST_DRAIN: begin
				state_d = S_EDGE_CHECK;
			end
			S_EDGE_CHECK: begin
				if (stat.list_hit) begin
					st_d    = ST_EDGE_EXISTS;
					state_d = S_RESULT;
				end else if (!stat.room_ok) begin
					st_d    = ST_FULL;
					state_d = S_RESULT;
				end else begin
					cmd.edge_wr1 = 1'b1;
					state_d      = S_EDGE_WR2;
				end
			end
			S_EDGE_WR2: begin
				cmd.edge_wr2 = 1'b1;
				st_d         = ST_EDGE_ADDED;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_ADDED;
			rsp_valid_q <= 1'b0;
			status_q    <= '0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == S_RESULT && out_free) begin
				rsp_valid_q <= 1'b1;
				status_q    <= st_q;
			end
		end
	end

endmodule

[dv/graph_adjacency_table_unit_tb.sv]
// graph_adjacency_table_unit_tb: self-checking bench for the graph adjacency table,
// predicting every status word from its own copy of the vertex table and edge lists
// depends on gat_pkg and graph_adjacency_table_unit
`timescale 1ns / 1ps

module graph_adjacency_table_unit_tb;
	import gat_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CLK_HALF     = 4;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE_WORDS  = 410;
	localparam int ID_POOL_SIZE = 22;

	typedef struct {
		logic [OP_W-1:0]        op;
		logic [ID_W-1:0]        vid;
		logic [ID_W-1:0]        oid;
		logic signed [WT_W-1:0] wt;
	} request_word_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   req_valid = 1'b0;
	logic                   req_ready;
	logic [OP_W-1:0]        operation = '0;
	logic [ID_W-1:0]        vertex_id = '0;
	logic [ID_W-1:0]        other_id = '0;
	logic signed [WT_W-1:0] edge_weight = '0;
	logic                   rsp_valid;
	logic                   rsp_ready = 1'b0;
	logic [ST_W-1:0]        status;

	request_word_t pending_words[$];
	status_t       status_expected[$];
	logic [ID_W-1:0] id_pool [ID_POOL_SIZE];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          req_taken = 1'b0;
	bit          hold_request = 1'b0;
	bit          hold_used = 1'b0;
	int          hold_left = 0;
	int          cycle_count = 0;
	int          words_sent = 0;
	int          status_checked = 0;
	int          mismatch_count = 0;
	int          status_seen [8];

	// predicted table contents
	logic [ID_W-1:0]        vtx_id   [MAX_VERTICES];
	bit                     vtx_live [MAX_VERTICES];
	int                     list_len [MAX_VERTICES];
	logic [ID_W-1:0]        list_nbr [MAX_VERTICES][MAX_EDGES_PER_VERTEX];
	logic signed [WT_W-1:0] list_wt  [MAX_VERTICES][MAX_EDGES_PER_VERTEX];

	graph_adjacency_table_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.operation   (operation),
		.vertex_id   (vertex_id),
		.other_id    (other_id),
		.edge_weight (edge_weight),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// lowest live slot holding the id, or -1
	function automatic int find_vertex(logic [ID_W-1:0] id);
		int hit;
		hit = -1;
		for (int s = MAX_VERTICES - 1; s >= 0; s--)
			if (vtx_live[s] && vtx_id[s] == id)
				hit = s;
		return hit;
	endfunction

	function automatic void append_entry(int s, logic [ID_W-1:0] nbr, logic signed [WT_W-1:0] wt);
		list_nbr[s][list_len[s]] = nbr;
		list_wt[s][list_len[s]]  = wt;
		list_len[s]++;
	endfunction

	// apply one request word to the predicted table, return its status
	function automatic status_t apply_request(request_word_t w);
		int sa;
		int sb;
		int sf;
		bit dup;
		bit no_room;
		status_t st;
		sa = find_vertex(w.vid);
		sb = find_vertex(w.oid);
		sf = -1;
		dup = 1'b0;
		for (int s = MAX_VERTICES - 1; s >= 0; s--)
			if (!vtx_live[s])
				sf = s;
		case (w.op)
			OP_ADD_VERTEX: begin
				if (sa >= 0)
					st = ST_EXISTS;
				else if (sf < 0)
					st = ST_FULL;
				else begin
					vtx_id[sf]   = w.vid;
					vtx_live[sf] = 1'b1;
					list_len[sf] = 0;
					st = ST_ADDED;
				end
			end
			OP_DEL_VERTEX: begin
				if (sa < 0)
					st = ST_NOT_FOUND;
				else begin
					vtx_live[sa] = 1'b0;
					list_len[sa] = 0;
					st = ST_DELETED;
				end
			end
			OP_ADD_EDGE: begin
				if (sa < 0 || sb < 0)
					st = ST_INVALID;
				else begin
					for (int k = 0; k < list_len[sa]; k++)
						if (list_nbr[sa][k] == w.oid)
							dup = 1'b1;
					// a self loop takes two entries of the same list
					if (sa == sb)
						no_room = list_len[sa] + 2 > MAX_EDGES_PER_VERTEX;
					else
						no_room = list_len[sa] >= MAX_EDGES_PER_VERTEX ||
							list_len[sb] >= MAX_EDGES_PER_VERTEX;
					if (dup)
						st = ST_EDGE_EXISTS;
					else if (no_room)
						st = ST_FULL;
					else begin
						append_entry(sa, w.oid, w.wt);
						append_entry(sb, w.vid, w.wt);
						st = ST_EDGE_ADDED;
					end
				end
			end
			default: st = ST_INVALID;
		endcase
		return st;
	endfunction

	task automatic queue_word(logic [OP_W-1:0] op, logic [ID_W-1:0] vid,
			logic [ID_W-1:0] oid, logic signed [WT_W-1:0] wt);
		request_word_t w;
		w.op  = op;
		w.vid = vid;
		w.oid = oid;
		w.wt  = wt;
		pending_words.insert(pending_words.size(), w);
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(99) < 90)
			return id_pool[$urandom_range(ID_POOL_SIZE - 1)];
		return ID_W'($urandom());
	endfunction

	// mostly table operations on a small id pool, the rest noise
	task automatic queue_random_words(int n);
		int r;
		logic signed [WT_W-1:0] wt;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			case ($urandom_range(9))
				0: wt = 16'sh8000;
				1: wt = 16'sh7fff;
				default: wt = WT_W'($urandom());
			endcase
			if (r < 22)
				queue_word(OP_ADD_VERTEX, pick_id(), ID_W'($urandom()), wt);
			else if (r < 28)
				queue_word(OP_DEL_VERTEX, pick_id(), ID_W'($urandom()), wt);
			else if (r < 92)
				queue_word(OP_ADD_EDGE, pick_id(), pick_id(), wt);
			else if (r < 96)
				queue_word(OP_UNUSED, pick_id(), pick_id(), wt);
			else
				queue_word(OP_W'($urandom()), ID_W'($urandom()), ID_W'($urandom()), wt);
		end
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || req_valid || status_expected.size() != 0)
			@(negedge clk);
	endtask

	// request driver: hold the word until taken, then maybe idle
	always @(negedge clk) begin
		request_word_t w;
		if (!arst_n)
			req_valid <= 1'b0;
		else if (!req_valid || req_taken) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				w = pending_words.pop_front();
				req_valid   <= 1'b1;
				operation   <= w.op;
				vertex_id   <= w.vid;
				other_id    <= w.oid;
				edge_weight <= w.wt;
			end else
				req_valid <= 1'b0;
		end
	end

	// long response hold, counted here once requested
	always @(negedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (hold_request && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end
	end

	// response side back-pressure
	always @(negedge clk) begin
		if (!arst_n)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor: check status words in order, predict on each accepted request
	always @(posedge clk) begin
		request_word_t w;
		status_t exp_st;
		req_taken <= arst_n && req_valid && req_ready;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (status_expected.size() == 0) begin
				$display("%0t: status word %0d with nothing expected", $time, status);
				mismatch_count++;
			end else begin
				exp_st = status_expected.pop_front();
				status_checked++;
				if (status !== exp_st) begin
					$display("%0t: status mismatch, expected %s (%0d), actual %0d",
						$time, exp_st.name(), exp_st, status);
					mismatch_count++;
				end else
					status_seen[exp_st]++;
			end
		end
		if (arst_n && req_valid && req_ready) begin
			w.op  = operation;
			w.vid = vertex_id;
			w.oid = other_id;
			w.wt  = edge_weight;
			status_expected.insert(status_expected.size(), apply_request(w));
			words_sent++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
			$display("** graph_adjacency_table_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hffff;
		for (int i = 2; i < ID_POOL_SIZE; i++)
			id_pool[i] = ID_W'($urandom());

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, duplicates, extremes, self loop, stale edges, full table
		queue_word(OP_DEL_VERTEX, 16'h0000, 16'h0000, 16'sh0000);
		queue_word(OP_ADD_VERTEX, 16'h0000, 16'hffff, 16'sh0000);
		queue_word(OP_ADD_VERTEX, 16'h0000, 16'h0000, 16'sh0000);
		queue_word(OP_ADD_VERTEX, 16'hffff, 16'h0000, 16'sh7fff);
		queue_word(OP_ADD_EDGE,   16'h0000, 16'hffff, 16'sh8000);
		queue_word(OP_ADD_EDGE,   16'hffff, 16'h0000, 16'sh7fff);
		queue_word(OP_ADD_EDGE,   16'h0000, 16'h0000, 16'sh0000);
		queue_word(OP_ADD_EDGE,   16'h0000, 16'h1234, 16'sh0001);
		queue_word(OP_UNUSED,     16'hffff, 16'hffff, 16'shffff);
		queue_word(OP_DEL_VERTEX, 16'hffff, 16'h0000, 16'sh0000);
		queue_word(OP_ADD_VERTEX, 16'hffff, 16'h0000, 16'sh0000);
		// origin still lists the deleted id, so this one is refused
		queue_word(OP_ADD_EDGE,   16'h0000, 16'hffff, 16'sh0005);
		queue_word(OP_ADD_EDGE,   16'hffff, 16'h0000, 16'sh0005);
		for (int i = 1; i <= MAX_VERTICES - 2; i++)
			queue_word(OP_ADD_VERTEX, ID_W'(16'h0100 + i), 16'h0000, 16'sh0000);
		queue_word(OP_ADD_VERTEX, 16'h0200, 16'h0000, 16'sh0000);
		wait_drained();

		// random phases with different idling
		send_idle_pct = 0;  recv_idle_pct = 0;
		queue_random_words(PHASE_WORDS);
		wait_drained();
		send_idle_pct = 61; recv_idle_pct = 0;
		queue_random_words(PHASE_WORDS);
		wait_drained();
		send_idle_pct = 0;  recv_idle_pct = 61;
		queue_random_words(PHASE_WORDS);
		wait_drained();
		send_idle_pct = 14; recv_idle_pct = 14;
		queue_random_words(PHASE_WORDS);
		wait_drained();

		// back-pressure: responses held off while requests keep coming
		send_idle_pct = 0;  recv_idle_pct = 0;
		hold_request = 1'b1;
		queue_random_words(60);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (status_expected.size() != 0) begin
			$display("%0t: %0d status words never arrived", $time, status_expected.size());
			mismatch_count++;
		end

		$display("run covered %0d request words and %0d status words over four idling phases",
			words_sent, status_checked);
		$display("plus a %0d-cycle response hold; status mix: %0d %0d %0d %0d %0d %0d %0d %0d",
			HOLD_CYCLES, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
		if (mismatch_count == 0)
			$display("** graph_adjacency_table_unit: PASSED **");
		else
			$display("** graph_adjacency_table_unit: FAILED **");
		$finish;
	end

endmodule

[sim.f]
sv/gat_pkg.sv
sv/gat_ram.sv
sv/gat_datapath.sv
sv/gat_ctrl.sv
sv/graph_adjacency_table_unit.sv
dv/graph_adjacency_table_unit_tb.sv
